[rtl/core/uart_rx_fifo_frame_gap_macros.svh]
// ----------------------------------------------------------------------------
// uart_rx_fifo_frame_gap assertion macros
// Short forms for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef UART_RX_FIFO_FRAME_GAP_MACROS_SVH
`define UART_RX_FIFO_FRAME_GAP_MACROS_SVH

// same-cycle implication, held off during reset
`define URXFG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("urxfg same-cycle check failed");

// next-cycle implication, held off during reset
`define URXFG_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("urxfg next-cycle check failed");

`endif

[rtl/core/urxfg_pkg.sv]
// ----------------------------------------------------------------------------
// urxfg_pkg
// Shared widths, request codes, state encoding and control structs for the
// receive FIFO with idle-gap frame detection.
// ----------------------------------------------------------------------------
`default_nettype none

package urxfg_pkg;

	// field widths
	localparam int unsigned REQ_W   = 3;
	localparam int unsigned DATA_W  = 8;
	localparam int unsigned OFF_W   = 8;
	localparam int unsigned GAP_W   = 16;
	localparam int unsigned FRAME_W = 8;

	// defaults
	localparam int unsigned          DEF_QUEUE_DEPTH = 256;
	localparam logic [GAP_W-1:0]     GAP_RESET       = 16'd10;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_BYTE  = 3'd0,
		REQ_TICK  = 3'd1,
		REQ_POP   = 3'd2,
		REQ_PEEK  = 3'd3,
		REQ_FRAME = 3'd4
	} req_type_t;

	// controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr;
		logic step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/urxfg_if.sv]
// ----------------------------------------------------------------------------
// urxfg channel interfaces
// Request channel into the FIFO and result channel out of it, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface urxfg_in_if import urxfg_pkg::*;;
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [DATA_W-1:0]  rx_byte;
	logic [OFF_W-1:0]   peek_offset;

	modport source (output valid, output req_type, output rx_byte, output peek_offset,
		input ready);
	modport sink (input valid, input req_type, input rx_byte, input peek_offset,
		output ready);
endinterface

interface urxfg_out_if import urxfg_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  read_data;
	logic               read_valid;
	logic               byte_accepted;
	logic [CNT_W-1:0]   fill_count;
	logic               overflow_flag;
	logic [FRAME_W-1:0] frame_count;

	modport source (output valid, output read_data, output read_valid,
		output byte_accepted, output fill_count, output overflow_flag,
		output frame_count, input ready);
	modport sink (input valid, input read_data, input read_valid,
		input byte_accepted, input fill_count, input overflow_flag,
		input frame_count, output ready);
endinterface

`default_nettype wire

[rtl/core/urxfg_ctrl.sv]
// ----------------------------------------------------------------------------
// urxfg_ctrl
// Sequencer: clearing pass after reset, then one item at a time with the
// result held until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module urxfg_ctrl import urxfg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.step = in_valid;
			end
			ST_RESULT: begin
				out_valid = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/urxfg_dp.sv]
// ----------------------------------------------------------------------------
// urxfg_dp
// Ring memory, head/tail/count, overflow bit, gap timer and frame counter.
// Queue, timer and frame state moves on the accept edge of an item.
// ----------------------------------------------------------------------------
`default_nettype none

module urxfg_dp import urxfg_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cmd_t                       cmd,
	output sts_t                            sts,
	input  wire logic [REQ_W-1:0]           req_type,
	input  wire logic [DATA_W-1:0]          rx_byte,
	input  wire logic [OFF_W-1:0]           peek_offset,
	input  wire logic                       cfg_we,
	input  wire logic [GAP_W-1:0]           cfg_wdata,
	output logic [DATA_W-1:0]               read_data,
	output logic                            read_valid,
	output logic                            byte_accepted,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] fill_count,
	output logic                            overflow_flag,
	output logic [FRAME_W-1:0]              frame_count
);

	localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned NOFF  = 2 ** OFF_W;

	localparam logic [AW-1:0]    LAST_IDX = AW'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [AW:0]      DEPTH_W  = (AW+1)'(QUEUE_DEPTH);

	// offset reduced modulo the depth, built at elaboration
	typedef logic [AW-1:0] off_tbl_t [NOFF];

	function automatic off_tbl_t build_off_mod();
		off_tbl_t t;
		for (int i = 0; i < NOFF; i++) begin
			t[i] = AW'(i % QUEUE_DEPTH);
		end
		return t;
	endfunction

	localparam off_tbl_t OFF_MOD = build_off_mod();

	logic [DATA_W-1:0]  mem [QUEUE_DEPTH];

	logic [AW-1:0]      head_q;
	logic [AW-1:0]      tail_q;
	logic [CNT_W-1:0]   count_q;
	logic [GAP_W-1:0]   timer_q;
	logic               running_q;
	logic               ovf_q;
	logic [FRAME_W-1:0] frames_q;
	logic [GAP_W-1:0]   gap_q;
	logic [AW-1:0]      clr_q;
	logic [DATA_W-1:0]  rdata_q;
	logic               rvalid_q;
	logic               acc_q;

	req_type_t          req;
	logic               full;
	logic               empty;
	logic               last_slot;
	logic [AW-1:0]      head_inc;
	logic [AW-1:0]      tail_inc;
	logic [AW:0]        peek_sum;
	logic [AW-1:0]      peek_addr;
	logic [GAP_W-1:0]   timer_inc;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               mem_we;
	logic [AW-1:0]      wr_addr;
	logic [DATA_W-1:0]  wr_data;

	assign req       = req_type_t'(req_type);
	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign last_slot = (count_q == FULL_CNT - CNT_W'(1));
	assign head_inc  = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
	assign tail_inc  = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
	assign timer_inc = timer_q + GAP_W'(1);

	// peek address: head plus reduced offset, one conditional subtract
	assign peek_sum  = {1'b0, head_q} + {1'b0, OFF_MOD[peek_offset]};
	assign peek_addr = (peek_sum >= DEPTH_W) ? AW'(peek_sum - DEPTH_W) : peek_sum[AW-1:0];

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		mem_we  = 1'b0;
		wr_addr = tail_q;
		wr_data = rx_byte;
		if (cmd.clr) begin
			mem_we  = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (cmd.step) begin
			unique case (req)
				REQ_BYTE:  mem_we = !full;
				REQ_POP:   rd_en  = !empty;
				REQ_PEEK: begin
					rd_en   = 1'b1;
					rd_addr = peek_addr;
				end
				default: begin
					rd_en  = 1'b0;
					mem_we = 1'b0;
				end
			endcase
		end
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= (clr_q == LAST_IDX) ? '0 : clr_q + AW'(1);
		end
	end

	assign sts.clr_last = (clr_q == LAST_IDX);

	// gap limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_RESET;
		end else if (cfg_we) begin
			gap_q <= cfg_wdata;
		end
	end

	// queue, timer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			timer_q   <= '0;
			running_q <= 1'b0;
			ovf_q     <= 1'b0;
			frames_q  <= '0;
			rvalid_q  <= 1'b0;
			acc_q     <= 1'b0;
		end else if (cmd.step) begin
			unique case (req)
				REQ_BYTE: begin
					rvalid_q <= 1'b0;
					if (full) begin
						acc_q     <= 1'b0;
						running_q <= 1'b0;
						ovf_q     <= 1'b1;
					end else begin
						tail_q    <= tail_inc;
						count_q   <= count_q + CNT_W'(1);
						acc_q     <= 1'b1;
						timer_q   <= '0;
						ovf_q     <= last_slot;
						running_q <= !last_slot;
					end
				end
				REQ_TICK: begin
					rvalid_q <= 1'b0;
					acc_q    <= 1'b0;
					if (running_q) begin
						if (timer_inc == gap_q) begin
							frames_q  <= frames_q + FRAME_W'(1);
							running_q <= 1'b0;
							timer_q   <= '0;
						end else begin
							timer_q <= timer_inc;
						end
					end
				end
				REQ_POP: begin
					rvalid_q <= !empty;
					acc_q    <= 1'b0;
					if (!empty) begin
						head_q  <= head_inc;
						count_q <= count_q - CNT_W'(1);
					end
				end
				REQ_PEEK: begin
					rvalid_q <= 1'b1;
					acc_q    <= 1'b0;
				end
				REQ_FRAME: begin
					rvalid_q <= 1'b0;
					acc_q    <= 1'b0;
					if (frames_q != '0) frames_q <= frames_q - FRAME_W'(1);
				end
				default: begin
					rvalid_q <= 1'b0;
					acc_q    <= 1'b0;
				end
			endcase
		end
	end

	// result fields
	assign read_data     = rvalid_q ? rdata_q : '0;
	assign read_valid    = rvalid_q;
	assign byte_accepted = acc_q;
	assign fill_count    = count_q;
	assign overflow_flag = ovf_q;
	assign frame_count   = frames_q;

endmodule

`default_nettype wire

[rtl/core/uart_rx_fifo_frame_gap.sv]
// ----------------------------------------------------------------------------
// uart_rx_fifo_frame_gap
// Receive byte FIFO with idle-gap frame detection.
// ----------------------------------------------------------------------------
//  channel  direction  handshake        payload
//  req      in         valid / ready    req_type, rx_byte, peek_offset
//  rsp      out        valid / ready    read_data, read_valid, byte_accepted,
//                                       fill_count, overflow_flag, frame_count
//  cfg      in         cfg_we           cfg_wdata (frame gap in ticks)
//
// For each item the accept edge updates the queue state and the
// single-port memory read, and the next cycle presents the result.
// The result stays until rsp.ready; no new item is taken meanwhile.
// After reset a clearing pass over every slot zeroes the ring memory;
// req.ready stays low during it. Configuration writes are taken any time.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rx_fifo_frame_gap import urxfg_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	urxfg_in_if.sink               req,
	urxfg_out_if.source            rsp,
	input  wire logic              cfg_we,
	input  wire logic [GAP_W-1:0]  cfg_wdata
);

	`include "uart_rx_fifo_frame_gap_macros.svh"

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	urxfg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and counters
	urxfg_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req.req_type),
		.rx_byte       (req.rx_byte),
		.peek_offset   (req.peek_offset),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.read_data     (rsp.read_data),
		.read_valid    (rsp.read_valid),
		.byte_accepted (rsp.byte_accepted),
		.fill_count    (rsp.fill_count),
		.overflow_flag (rsp.overflow_flag),
		.frame_count   (rsp.frame_count)
	);

	// checks
	`URXFG_ASSERT_IMP(a_fill_bound, 1'b1, rsp.fill_count <= CNT_W'(QUEUE_DEPTH))
	`URXFG_ASSERT_IMP(a_one_in_flight, rsp.valid, !req.ready)
	`URXFG_ASSERT_NXT(a_result_follows, req.valid && req.ready, rsp.valid)
	`URXFG_ASSERT_IMP(a_byte_no_read, rsp.valid && rsp.byte_accepted, !rsp.read_valid)

endmodule

`default_nettype wire

[tb/tb_uart_rx_fifo_frame_gap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_rx_fifo_frame_gap
// Self-checking bench for the receive FIFO with idle-gap frame detection.
// Requests are driven from a queue through the request channel. A local
// FIFO and timer model predicts one result for every accepted item, and
// each result is checked field by field in arrival order. The run covers
// directed corner items, a full-ring and frame-count wrap sequence, and
// random traffic under several frame gap settings, with random stalls on
// both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_uart_rx_fifo_frame_gap;
	import urxfg_pkg::*;

	localparam int unsigned DEPTH = DEF_QUEUE_DEPTH;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	// request codes the block does not use
	localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [DATA_W-1:0] data;
		logic [OFF_W-1:0]  offset;
	} rx_req_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic               read_valid;
		logic               byte_accepted;
		logic [CNT_W-1:0]   fill_count;
		logic               overflow_flag;
		logic [FRAME_W-1:0] frame_count;
	} rx_result_t;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we;
	logic [GAP_W-1:0] cfg_wdata;

	urxfg_in_if                             req_ch ();
	urxfg_out_if #(.QUEUE_DEPTH(DEPTH))     rsp_ch ();

	uart_rx_fifo_frame_gap #(.QUEUE_DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// stimulus and expectation stores
	rx_req_t    pending_q[$];
	rx_result_t expect_q[$];
	rx_req_t    drv_item;
	rx_req_t    seen_item;
	rx_result_t want;
	rx_result_t got;

	bit in_fire   = 1'b0;
	bit idle_on   = 1'b0;
	bit rsp_hold  = 1'b0;
	int src_gap   = 0;
	int snk_gap   = 0;
	int err_cnt   = 0;
	int pushed_cnt = 0;
	int gen_fill  = 0;
	int gen_gap   = 10;

	// local copy of the FIFO and gap timer
	logic [DATA_W-1:0]  ring_m [DEPTH];
	logic [IDX_W-1:0]   head_m;
	logic [IDX_W-1:0]   tail_m;
	logic [CNT_W-1:0]   fill_m;
	logic [GAP_W-1:0]   gap_tmr_m;
	logic               tmr_run_m;
	logic               ovf_m;
	logic [FRAME_W-1:0] frames_m;
	logic [GAP_W-1:0]   gap_limit_m;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// advance the local FIFO model by one item and return its result
	function automatic rx_result_t fifo_step(rx_req_t it);
		rx_result_t       r;
		logic [IDX_W-1:0] pos;
		r = '0;
		case (it.kind)
			REQ_BYTE: begin
				if (fill_m == DEPTH) begin
					// full ring: drop, timer holds its value
					tmr_run_m = 1'b0;
					ovf_m     = 1'b1;
				end else begin
					ring_m[tail_m] = it.data;
					tail_m         = tail_m + 1'b1;
					fill_m         = fill_m + 1'b1;
					r.byte_accepted = 1'b1;
					gap_tmr_m      = '0;
					if (fill_m == DEPTH) begin
						ovf_m     = 1'b1;
						tmr_run_m = 1'b0;
					end else begin
						ovf_m     = 1'b0;
						tmr_run_m = 1'b1;
					end
				end
			end
			REQ_TICK: begin
				if (tmr_run_m) begin
					gap_tmr_m = gap_tmr_m + 1'b1;
					if (gap_tmr_m == gap_limit_m) begin
						frames_m  = frames_m + 1'b1;
						tmr_run_m = 1'b0;
						gap_tmr_m = '0;
					end
				end
			end
			REQ_POP: begin
				if (fill_m != 0) begin
					r.read_data  = ring_m[head_m];
					r.read_valid = 1'b1;
					head_m       = head_m + 1'b1;
					fill_m       = fill_m - 1'b1;
				end
			end
			REQ_PEEK: begin
				// no bounds check, any slot may be read
				pos          = head_m + IDX_W'(it.offset);
				r.read_data  = ring_m[pos];
				r.read_valid = 1'b1;
			end
			REQ_FRAME: begin
				if (frames_m != 0)
					frames_m = frames_m - 1'b1;
			end
			default: ;
		endcase
		r.fill_count    = fill_m;
		r.overflow_flag = ovf_m;
		r.frame_count   = frames_m;
		return r;
	endfunction

	task automatic check_field(string nm, logic [15:0] exp_v, logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// result check, then prediction for an item taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.read_data     = rsp_ch.read_data;
				got.read_valid    = rsp_ch.read_valid;
				got.byte_accepted = rsp_ch.byte_accepted;
				got.fill_count    = rsp_ch.fill_count;
				got.overflow_flag = rsp_ch.overflow_flag;
				got.frame_count   = rsp_ch.frame_count;
				if (expect_q.size() == 0) begin
					$display("%0t: result with none expected, actual %0h", $time, got);
					err_cnt++;
				end else begin
					want = expect_q.pop_front();
					check_field("read_data", 16'(want.read_data), 16'(got.read_data));
					check_field("read_valid", 16'(want.read_valid), 16'(got.read_valid));
					check_field("byte_accepted", 16'(want.byte_accepted),
						16'(got.byte_accepted));
					check_field("fill_count", 16'(want.fill_count), 16'(got.fill_count));
					check_field("overflow_flag", 16'(want.overflow_flag),
						16'(got.overflow_flag));
					check_field("frame_count", 16'(want.frame_count), 16'(got.frame_count));
				end
			end
			in_fire <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				seen_item.kind   = req_ch.req_type;
				seen_item.data   = req_ch.rx_byte;
				seen_item.offset = req_ch.peek_offset;
				expect_q.push_back(fifo_step(seen_item));
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || in_fire) begin
			if (src_gap > 0 || pending_q.size() == 0) begin
				if (src_gap > 0)
					src_gap--;
				req_ch.valid <= 1'b0;
			end else begin
				drv_item = pending_q.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.req_type    <= drv_item.kind;
				req_ch.rx_byte     <= drv_item.data;
				req_ch.peek_offset <= drv_item.offset;
				if (idle_on && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 4);
			end
		end
	end

	// result receiver with random stalls
	always @(negedge clk) begin
		if (!arst_n || rsp_hold) begin
			rsp_ch.ready <= 1'b0;
		end else if (snk_gap > 0) begin
			snk_gap--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (idle_on && $urandom_range(0, 5) == 0)
				snk_gap = $urandom_range(1, 4);
		end
	end

	task automatic push_item(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] data,
		logic [OFF_W-1:0] offset);
		rx_req_t it;
		it.kind   = kind;
		it.data   = data;
		it.offset = offset;
		pending_q.push_back(it);
		pushed_cnt++;
		if (kind == REQ_BYTE && gen_fill < DEPTH)
			gen_fill++;
		else if (kind == REQ_POP && gen_fill > 0)
			gen_fill--;
	endtask

	task automatic push_rand(logic [REQ_W-1:0] kind);
		push_item(kind, DATA_W'($urandom_range(0, 255)), OFF_W'($urandom_range(0, 255)));
	endtask

	task automatic push_drain();
		while (gen_fill > 0)
			push_rand(($urandom_range(0, 5) == 0) ? REQ_PEEK : REQ_POP);
	endtask

	// random traffic: mostly byte bursts followed by idle ticks
	task automatic push_traffic(int n_items);
		int first;
		int pick;
		int n_tick;
		first = pushed_cnt;
		while (pushed_cnt - first < n_items) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				repeat ($urandom_range(1, 6)) push_rand(REQ_BYTE);
				if (gen_gap <= 16)
					n_tick = gen_gap - 1 + $urandom_range(0, 2);
				else
					n_tick = $urandom_range(1, 20);
				repeat (n_tick) push_rand(REQ_TICK);
				if ($urandom_range(0, 1))
					push_rand(REQ_FRAME);
			end else if (pick < 7) begin
				repeat ($urandom_range(1, 4))
					push_rand(($urandom_range(0, 3) == 0) ? REQ_PEEK : REQ_POP);
			end else if (pick == 7) begin
				push_rand(REQ_FRAME);
			end else begin
				push_rand(REQ_W'($urandom_range(0, 7)));
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_q.size() > 0 || req_ch.valid || expect_q.size() > 0)
			@(posedge clk);
	endtask

	// write the frame gap while the block is idle
	task automatic write_gap(logic [GAP_W-1:0] val);
		repeat (2) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		gap_limit_m = val;
		gen_gap     = int'(val);
	endtask

	// stimulus sequence
	initial begin
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_BYTE;
		req_ch.rx_byte     = '0;
		req_ch.peek_offset = '0;
		rsp_ch.ready       = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		for (int i = 0; i < DEPTH; i++)
			ring_m[i] = '0;
		head_m      = '0;
		tail_m      = '0;
		fill_m      = '0;
		gap_tmr_m   = '0;
		tmr_run_m   = 1'b0;
		ovf_m       = 1'b0;
		frames_m    = '0;
		gap_limit_m = GAP_RESET;
		gen_gap     = int'(GAP_RESET);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner items under the reset gap
		push_item(REQ_FRAME, 8'h00, 8'h00);
		push_item(REQ_POP, 8'hff, 8'hff);
		push_item(REQ_TICK, 8'h00, 8'h00);
		push_item(REQ_PEEK, 8'h00, 8'hff);
		push_item(REQ_BYTE, 8'h00, 8'h00);
		push_item(REQ_BYTE, 8'hff, 8'hff);
		push_item(REQ_BYTE, 8'h55, 8'haa);
		repeat (10) push_item(REQ_TICK, 8'haa, 8'h55);
		push_item(REQ_PEEK, 8'h00, 8'haa);
		push_item(REQ_PEEK, 8'h00, 8'h55);
		push_item(REQ_PEEK, 8'h00, 8'h01);
		push_item(REQ_POP, 8'h00, 8'h00);
		push_item(REQ_FRAME, 8'h00, 8'h00);
		for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
			push_rand(REQ_W'(k));
		wait_drained();

		// shortest gap: fill the ring one frame per byte, wrap the frame count
		idle_on = 1'b1;
		write_gap(16'd1);
		push_drain();
		repeat (DEPTH - 1) begin
			push_rand(REQ_BYTE);
			push_rand(REQ_TICK);
		end
		push_rand(REQ_BYTE);
		push_rand(REQ_BYTE);
		push_rand(REQ_TICK);
		push_rand(REQ_POP);
		push_rand(REQ_POP);
		push_rand(REQ_BYTE);
		push_rand(REQ_TICK);
		push_drain();
		// long receiver hold-off while requests keep coming
		repeat (40) @(posedge clk);
		rsp_hold = 1'b1;
		repeat (300) @(posedge clk);
		rsp_hold = 1'b0;
		wait_drained();

		// longest gap: timer never expires
		write_gap(16'hffff);
		push_traffic(175);
		wait_drained();

		write_gap(16'd3);
		push_traffic(200);
		wait_drained();

		// last part without idling
		idle_on = 1'b0;
		write_gap(GAP_W'($urandom_range(2, 9)));
		push_traffic(150);
		wait_drained();

		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/urxfg_pkg.sv
rtl/core/urxfg_if.sv
rtl/core/urxfg_ctrl.sv
rtl/core/urxfg_dp.sv
rtl/core/uart_rx_fifo_frame_gap.sv
tb/tb_uart_rx_fifo_frame_gap.sv
